[rtl/assert_macros.svh]
// Assertion macros shared by the deframer modules.
// No dependencies; take in by include inside the asserting modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/phd_pkg.sv]
// Shared types, constants and the frame size table for the header deframer.
// No dependencies.
`default_nettype none

package phd_pkg;

  localparam logic [2:0]  RetryLimit       = 3'd5;
  localparam logic [3:0]  EmptyHeaderLimit = 4'd10;
  localparam logic [3:0]  TimeoutLimit     = 4'd10;
  localparam int          MaxFrameDefault  = 4096;

  localparam logic [7:0]  CtlCode          = 8'd9;
  localparam logic [14:0] NoiseMult        = 15'd3;

  localparam logic [3:0]  SizeCodeReset    = 4'd2;
  localparam logic [7:0]  SyncReset        = 8'd16;
  localparam logic [15:0] CheckReset       = 16'hAAAA;

  localparam logic        CmdByte          = 1'b0;
  localparam logic        CmdTimeout       = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_FAILED  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_GOOD_CTL = 3'd0,
    KIND_BAD_CTL  = 3'd1,
    KIND_HEADER   = 3'd2,
    KIND_BYTE     = 3'd3,
    KIND_RETRY    = 3'd4,
    KIND_FAIL     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_FRAME_SIZE = 2'd0,
    REG_SYNC       = 2'd1,
    REG_CHECK      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]  size_code;
    logic [7:0]  sync_value;
    logic [15:0] check_const;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  control_byte;
    logic [15:0] check_word;
    logic [7:0]  data_byte;
    logic        last;
  } res_t;

  function automatic logic [12:0] frame_bytes(logic [3:0] code);
    logic [12:0] n;
    case (code)
      4'd1:    n = 13'd32;
      4'd2:    n = 13'd64;
      4'd3:    n = 13'd128;
      4'd4:    n = 13'd256;
      4'd5:    n = 13'd512;
      4'd6:    n = 13'd1024;
      4'd7:    n = 13'd2048;
      4'd8:    n = 13'd4096;
      default: n = 13'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/phd_cfg.sv]
// APB-style configuration registers of the header deframer.
// Depends on phd_pkg.
`default_nettype none

module phd_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output phd_pkg::cfg_t      cfg_o
);
  import phd_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_SIZE: cfg_d.size_code   = pwdata[3:0];
        REG_SYNC:       cfg_d.sync_value  = pwdata[7:0];
        REG_CHECK:      cfg_d.check_const = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_SIZE: prdata = {28'd0, cfg_q.size_code};
      REG_SYNC:       prdata = {24'd0, cfg_q.sync_value};
      REG_CHECK:      prdata = {16'd0, cfg_q.check_const};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_code   <= SizeCodeReset;
      cfg_q.sync_value  <= SyncReset;
      cfg_q.check_const <= CheckReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/phd_core.sv]
// Frame state machine, header store, counters and result decode.
// Depends on phd_pkg and assert_macros.svh.
`default_nettype none

module phd_core #(
  parameter int MAX_FRAME = phd_pkg::MaxFrameDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          command_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire phd_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output phd_pkg::res_t      res_o
);
  import phd_pkg::*;
  `include "assert_macros.svh"

  localparam int          PayW      = $clog2(MAX_FRAME + 1);
  localparam logic [12:0] MaxFrameW = 13'(MAX_FRAME);

  phase_e            phase_q, phase_d;
  logic [7:0]        hdr_q [4];
  logic [2:0]        idx_q, idx_d;
  logic [PayW-1:0]   left_q, left_d;
  logic [13:0]       noise_q, noise_d;
  logic [2:0]        try_q, try_d;
  logic [3:0]        empty_q, empty_d;
  logic [3:0]        tmo_q, tmo_d;

  logic        is_tmo;
  logic [12:0] size_w;
  logic [14:0] noise_bound;
  logic        noise_over, cfg_usable;
  logic        fail_hunt, ev_act, ev_tmo, ev_hdr_byte, ev_finish;
  logic        ev_sync, ev_noise, ev_try;
  logic [2:0]  try_inc;
  logic        try_fail;
  logic        xor_ok, is_ctl, data_match, ev_ctl, ev_data;
  logic        pay_tmo, pay_byte, pay_end;
  logic [15:0] chk_word, ctl_sum;

  assign is_tmo      = (command_i == CmdTimeout);
  assign size_w      = frame_bytes(cfg_i.size_code);
  assign noise_bound = {2'b00, size_w} * NoiseMult;
  assign noise_over  = {1'b0, noise_q} >= noise_bound;
  assign cfg_usable  = (cfg_i.size_code >= 4'd1) && (cfg_i.size_code <= 4'd8) &&
                       (size_w <= MaxFrameW);

  assign fail_hunt   = (phase_q == PH_HUNT) && (try_q == 3'd0) && (noise_q == 14'd0) &&
                       ((empty_q > EmptyHeaderLimit) || (tmo_q > TimeoutLimit));
  assign ev_act      = accept_i && ((phase_q == PH_HUNT) || (phase_q == PH_HEADER)) &&
                       !fail_hunt;
  assign ev_tmo      = ev_act && is_tmo;
  assign ev_hdr_byte = ev_act && !is_tmo && (phase_q == PH_HEADER);
  assign ev_finish   = ev_hdr_byte && (idx_q == 3'd4);
  assign ev_sync     = ev_act && !is_tmo && (phase_q == PH_HUNT) &&
                       (rx_byte_i == cfg_i.sync_value);
  assign ev_noise    = ev_act && !is_tmo && (phase_q == PH_HUNT) &&
                       (rx_byte_i != cfg_i.sync_value);
  assign ev_try      = ev_tmo || (ev_noise && noise_over);
  assign try_inc     = try_q + 3'd1;
  assign try_fail    = try_inc >= RetryLimit;

  assign chk_word    = {hdr_q[2], hdr_q[1]};
  assign ctl_sum     = chk_word + {8'd0, hdr_q[3]};
  assign xor_ok      = (hdr_q[0] ^ hdr_q[1] ^ hdr_q[2] ^ hdr_q[3]) == rx_byte_i;
  assign is_ctl      = (hdr_q[0] == CtlCode);
  assign data_match  = cfg_usable && (hdr_q[0] == {4'd0, cfg_i.size_code});
  assign ev_ctl      = ev_finish && xor_ok && is_ctl;
  assign ev_data     = ev_finish && xor_ok && !is_ctl && data_match;

  assign pay_tmo     = accept_i && (phase_q == PH_PAYLOAD) && is_tmo;
  assign pay_byte    = accept_i && (phase_q == PH_PAYLOAD) && !is_tmo;
  assign pay_end     = pay_byte && (left_q <= PayW'(1));

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_FAILED: ;
      PH_PAYLOAD: begin
        if (pay_tmo || pay_end) begin
          phase_d = PH_HUNT;
        end
      end
      PH_HUNT, PH_HEADER: begin
        if (accept_i && fail_hunt) begin
          phase_d = PH_FAILED;
        end else if (ev_try) begin
          phase_d = try_fail ? PH_FAILED : PH_HUNT;
        end else if (ev_sync) begin
          phase_d = PH_HEADER;
        end else if (ev_finish) begin
          phase_d = ev_data ? PH_PAYLOAD : PH_HUNT;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i && fail_hunt) begin
      res_valid_o = 1'b1;
      res_o.kind  = KIND_FAIL;
    end else if (ev_try) begin
      res_valid_o = 1'b1;
      res_o.kind  = try_fail ? KIND_FAIL : KIND_RETRY;
    end else if (ev_ctl || ev_data) begin
      res_valid_o        = 1'b1;
      res_o.control_byte = hdr_q[3];
      res_o.check_word   = chk_word;
      if (ev_data) begin
        res_o.kind = KIND_HEADER;
      end else begin
        res_o.kind = (ctl_sum == cfg_i.check_const) ? KIND_GOOD_CTL : KIND_BAD_CTL;
      end
    end else if (pay_byte) begin
      res_valid_o     = 1'b1;
      res_o.kind      = KIND_BYTE;
      res_o.data_byte = rx_byte_i;
      res_o.last      = pay_end;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    left_d  = left_q;
    noise_d = noise_q;
    try_d   = try_q;
    empty_d = empty_q;
    tmo_d   = tmo_q;
    if (ev_tmo) begin
      tmo_d = (tmo_q != 4'hF) ? tmo_q + 4'd1 : tmo_q;
      idx_d = 3'd0;
    end
    if (pay_tmo || pay_end) begin
      tmo_d  = 4'd0;
      left_d = '0;
    end else if (pay_byte) begin
      left_d = left_q - PayW'(1);
    end
    if (ev_sync) begin
      idx_d = 3'd0;
    end
    if (ev_hdr_byte) begin
      idx_d = ev_finish ? 3'd0 : idx_q + 3'd1;
    end
    if (ev_noise) begin
      noise_d = noise_over ? 14'd0 : noise_q + 14'd1;
    end
    if (ev_try) begin
      try_d = try_inc;
    end
    if (ev_finish) begin
      noise_d = 14'd0;
      try_d   = 3'd0;
      if (ev_data) begin
        empty_d = 4'd0;
        left_d  = size_w[PayW-1:0];
      end else begin
        empty_d = (empty_q != 4'hF) ? empty_q + 4'd1 : empty_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= 3'd0;
      left_q  <= '0;
      noise_q <= 14'd0;
      try_q   <= 3'd0;
      empty_q <= 4'd0;
      tmo_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      noise_q <= noise_d;
      try_q   <= try_d;
      empty_q <= empty_d;
      tmo_q   <= tmo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_hdr_byte && !ev_finish) begin
      hdr_q[idx_q[1:0]] <= rx_byte_i;
    end
  end

  `ASSERT_ALWAYS(a_payload_count, clk_i, rst_ni,
    (phase_q == PH_PAYLOAD) == (left_q != '0), "payload count out of step with phase")
  `ASSERT_IMPLIES(a_idx_outside_header, clk_i, rst_ni,
    phase_q != PH_HEADER, idx_q == 3'd0, "header index set outside the header phase")
  `ASSERT_IMPLIES(a_try_below_limit, clk_i, rst_ni,
    phase_q != PH_FAILED, try_q < RetryLimit, "try count at limit without failure")

endmodule

`default_nettype wire

[rtl/phd_out_buf.sv]
// Result register with one skid entry between the core and the output channel.
// Depends on phd_pkg and assert_macros.svh.
`default_nettype none

module phd_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire phd_pkg::res_t res_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output phd_pkg::res_t      res_o
);
  import phd_pkg::*;
  `include "assert_macros.svh"

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  `ASSERT_IMPLIES(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
    "skid entry held without an output item")
  `ASSERT_ALWAYS(a_no_push_when_full, clk_i, rst_ni,
    !(skid_valid_q && push_i), "item pushed into a full buffer")
  `ASSERT_ALWAYS(a_out_held_while_stalled, clk_i, rst_ni,
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q), "stalled item changed")

endmodule

`default_nettype wire

[rtl/packet_header_deframer.sv]
// Top level of the packet header deframer: configuration, core and output buffer.
// Depends on phd_pkg, phd_cfg, phd_core and phd_out_buf.
//
//   port group   direction  handshake             payload
//   input        in         in_valid_i/in_stall_o command_i, rx_byte_i
//   result       out        out_valid_o/out_stall_i kind_o, control_byte_o,
//                                                 check_word_o, data_byte_o, last_o
//   config       in         psel/penable/pwrite   paddr, pwdata, prdata
//
// One item per cycle while in_stall_o is low; results are registered on the way out.
// The frame state and counters update in the cycle the item is taken.
// Stall on the input rises only when the result register and the skid entry are full.
// Reset clears phase, counters and buffer flags; header bytes hold until written.
`default_nettype none

module packet_header_deframer #(
  parameter int MAX_FRAME = phd_pkg::MaxFrameDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       control_byte_o,
  output logic [15:0]      check_word_o,
  output logic [7:0]       data_byte_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import phd_pkg::*;

  cfg_t cfg;
  res_t core_res, out_res;
  logic core_valid;
  logic accept;
  logic buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  phd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  phd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (core_valid),
    .res_i       (core_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign control_byte_o = out_res.control_byte;
  assign check_word_o   = out_res.check_word;
  assign data_byte_o    = out_res.data_byte;
  assign last_o         = out_res.last;

endmodule

`default_nettype wire
